/* src/byte_range_gap_tracker_defines.svh */
// Assertion macros for the byte range gap tracker.
`ifndef BYTE_RANGE_GAP_TRACKER_DEFINES_SVH
`define BYTE_RANGE_GAP_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define BRGT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BRGT_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BRGT_ASSERT(label, clk, rst, prop, msg)
`define BRGT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* src/brgt_pkg.sv */
// Shared constants and types of the byte range gap tracker.
`timescale 1ns / 1ps
package brgt_pkg;

  localparam int DATA_W = 40;
  localparam int PBYTES_W = 24;
  localparam int PART_W = 16;
  localparam int LPN_W = 17;
  localparam int DIVCNT_W = 4;

  localparam int MAX_GAPS_DEFAULT = 64;
  localparam int PART_BYTES_DEFAULT = 9728000;

  localparam logic [DATA_W-1:0] MASK40 = {DATA_W{1'b1}};

  typedef enum logic [2:0] {
    REQ_INIT_CLEAR = 3'd0,
    REQ_INIT_ALL   = 3'd1,
    REQ_ADD        = 3'd2,
    REQ_FILL       = 3'd3,
    REQ_TOTAL      = 3'd4,
    REQ_PART_SIZE  = 3'd5,
    REQ_COMPLETE   = 3'd6
  } req_t;

  typedef struct packed {
    logic                 start;
    logic [DATA_W-1:0]    dividend;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DATA_W-1:0]    quotient;
    logic [PBYTES_W-1:0]  remainder;
  } div_rsp_t;

endpackage

/* src/brgt_gap_mem.sv */
// One bank of the gap table: one write port, one registered read port.
`timescale 1ns / 1ps
module brgt_gap_mem #(
  parameter int DEPTH = brgt_pkg::MAX_GAPS_DEFAULT,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [brgt_pkg::DATA_W-1:0] wstart,
  input  logic [brgt_pkg::DATA_W-1:0] wend,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [brgt_pkg::DATA_W-1:0] rstart,
  output logic [brgt_pkg::DATA_W-1:0] rend
);

  logic [brgt_pkg::DATA_W-1:0] mem_start [DEPTH];
  logic [brgt_pkg::DATA_W-1:0] mem_end [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_end[waddr]   <= wend;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rstart <= mem_start[raddr];
      rend   <= mem_end[raddr];
    end
  end

endmodule

/* src/brgt_div.sv */
// Division by the part size through a multi-cycle reciprocal multiply and one correction.
`timescale 1ns / 1ps
module brgt_div #(
  parameter int PART_BYTES = brgt_pkg::PART_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  brgt_pkg::div_req_t req,
  output brgt_pkg::div_rsp_t rsp
);

  localparam int DW = brgt_pkg::DATA_W;
  localparam int PW = brgt_pkg::PBYTES_W;
  localparam int HW = DW / 2;
  localparam int ACC_W = DW + 64;
  localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / 64'(PART_BYTES);
  localparam logic [PW-1:0] DIVISOR = PW'(PART_BYTES);
  localparam logic [brgt_pkg::DIVCNT_W-1:0] STEP_Q   = brgt_pkg::DIVCNT_W'(8);
  localparam logic [brgt_pkg::DIVCNT_W-1:0] STEP_LO  = brgt_pkg::DIVCNT_W'(9);
  localparam logic [brgt_pkg::DIVCNT_W-1:0] STEP_HI  = brgt_pkg::DIVCNT_W'(10);
  localparam logic [brgt_pkg::DIVCNT_W-1:0] STEP_FIX = brgt_pkg::DIVCNT_W'(11);

  logic                          busy;
  logic                          done;
  logic [brgt_pkg::DIVCNT_W-1:0] cnt;
  logic [DW-1:0]                 dvd;
  logic [DW-1:0]                 quo;
  logic [PW-1:0]                 rem;
  logic [ACC_W-1:0]              acc;
  logic [63:0]                   qd;
  logic [HW-1:0]                 x_part;
  logic [15:0]                   m_part;
  logic [HW+15:0]                pp;
  logic [6:0]                    sh;
  logic [ACC_W-1:0]              pp_sh;
  logic [HW-1:0]                 q_part;
  logic [HW+PW-1:0]              qd_pp;
  logic [DW-1:0]                 diff;
  logic                          fix;

  // partial products of dividend times reciprocal: two dividend halves by four slices
  assign x_part = cnt[0] ? dvd[DW-1:HW] : dvd[HW-1:0];

  always_comb begin
    case (cnt[2:1])
      2'd0: m_part = RECIP[15:0];
      2'd1: m_part = RECIP[31:16];
      2'd2: m_part = RECIP[47:32];
      default: m_part = RECIP[63:48];
    endcase
  end

  assign pp     = x_part * m_part;
  assign sh     = (cnt[0] ? 7'(HW) : 7'd0) + {1'b0, cnt[2:1], 4'b0};
  assign pp_sh  = {{(ACC_W - HW - 16){1'b0}}, pp} << sh;
  assign q_part = (cnt == STEP_HI) ? quo[DW-1:HW] : quo[HW-1:0];
  assign qd_pp  = q_part * DIVISOR;
  assign diff   = dvd - qd[DW-1:0];
  // the estimate is at most one low
  assign fix    = diff >= {{(DW - PW){1'b0}}, DIVISOR};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_FIX) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      acc <= '0;
    end else if (busy) begin
      if (cnt < STEP_Q) begin
        acc <= acc + pp_sh;
      end
      if (cnt == STEP_Q) begin
        quo <= acc[ACC_W-1:64];
      end
      if (cnt == STEP_LO) begin
        qd <= {{(64 - HW - PW){1'b0}}, qd_pp};
      end
      if (cnt == STEP_HI) begin
        qd <= qd + {qd_pp, {HW{1'b0}}};
      end
      if (cnt == STEP_FIX) begin
        quo <= fix ? quo + 1'b1 : quo;
        rem <= fix ? PW'(diff - {{(DW - PW){1'b0}}, DIVISOR}) : diff[PW-1:0];
      end
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

/* src/byte_range_gap_tracker.sv */
// Top level of the byte range gap tracker: sequencer over a ping-pong gap table.
// Usage:
//   Requests enter on in_valid/in_stall; a transfer happens when in_valid is
//   high and in_stall low. Every request gives exactly one result on
//   out_valid/out_stall with gap_bytes, is_complete and overflow.
//   file_size is written over the APB-style port at byte address 0 (64-bit
//   data, low 40 bits used); write it only while the block is idle.
//   A table request scans every gap, and each gap split in two or each merged
//   gap placed before a kept one takes an extra step in the split state. The
//   gap table is scanned one entry a cycle, except during those split steps,
//   through the registered read port of a memory; add and fill write the new table
//   into the other bank and swap banks at the end. Init waits for the
//   multi-cycle reciprocal divide that gives the last part size. One
//   request is worked on at a time; in_stall is high from acceptance until the
//   result is loaded.
//   The result register lets the next request enter while a result waits; a
//   stalled result holds until taken, and a finished request waits in turn.
//   Reset (synchronous, active high) empties the table, sets file_size to 1
//   and the last part to part 0 of full size. No clearing pass is needed.
//   A request that would need more than MAX_GAPS entries answers with
//   overflow and leaves the table unchanged.
`timescale 1ns / 1ps
`include "byte_range_gap_tracker_defines.svh"
module byte_range_gap_tracker #(
  parameter int MAX_GAPS = brgt_pkg::MAX_GAPS_DEFAULT,
  parameter int PART_BYTES = brgt_pkg::PART_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [brgt_pkg::DATA_W-1:0]   range_start,
  input  logic [brgt_pkg::DATA_W-1:0]   range_end,
  input  logic                          by_part,
  input  logic [brgt_pkg::PART_W-1:0]   part_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brgt_pkg::DATA_W-1:0]   gap_bytes,
  output logic                          is_complete,
  output logic                          overflow,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  localparam int AW = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
  localparam int CW = $clog2(MAX_GAPS + 1);
  localparam int DW = brgt_pkg::DATA_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_GAPS);
  localparam logic [brgt_pkg::PBYTES_W-1:0] PB = brgt_pkg::PBYTES_W'(PART_BYTES);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PREP  = 9'b000000010,
    ST_RANGE = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_START = 9'b000010000,
    ST_SCAN  = 9'b000100000,
    ST_SPLIT = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [DW-1:0] file_size;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[3] == 1'b0) ? {24'b0, file_size} : 64'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= DW'(1);
    end else if (cfg_wr && paddr[3] == 1'b0) begin
      file_size <= pwdata[DW-1:0];
    end
  end

  // latched request
  logic [2:0]                  req_r;
  logic [DW-1:0]               in_s;
  logic [DW-1:0]               in_e;
  logic                        by_part_r;
  logic [brgt_pkg::PART_W-1:0] part_r;
  logic [DW-1:0]               prod;

  // table state
  logic                        cur_bank;
  logic [CW-1:0]               gap_count;
  logic [brgt_pkg::LPN_W-1:0]  last_part_number;
  logic [brgt_pkg::PBYTES_W-1:0] last_part_bytes;

  // scan state
  logic [DW-1:0] s_r;
  logic [DW-1:0] e_r;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_n;
  logic          proc_valid;
  logic          placed;
  logic [DW-1:0] ms;
  logic [DW-1:0] me;
  logic [DW-1:0] hold_s;
  logic [DW-1:0] hold_e;
  logic [DW-1:0] acc;
  logic          ovf;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_ws;
  logic [DW-1:0] mem_wei;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] rs0, re0, rs1, re1;
  logic [DW-1:0] g_s, g_e;

  brgt_gap_mem #(.DEPTH(MAX_GAPS), .AW(AW)) u_bank0 (
    .clk(clk), .we(mem_we && cur_bank), .waddr(mem_waddr), .wstart(mem_ws), .wend(mem_wei),
    .re(mem_re), .raddr(mem_raddr), .rstart(rs0), .rend(re0)
  );

  brgt_gap_mem #(.DEPTH(MAX_GAPS), .AW(AW)) u_bank1 (
    .clk(clk), .we(mem_we && !cur_bank), .waddr(mem_waddr), .wstart(mem_ws), .wend(mem_wei),
    .re(mem_re), .raddr(mem_raddr), .rstart(rs1), .rend(re1)
  );

  assign g_s = cur_bank ? rs1 : rs0;
  assign g_e = cur_bank ? re1 : re0;

  // divider for init
  brgt_pkg::div_req_t div_req;
  brgt_pkg::div_rsp_t div_rsp;

  brgt_div #(.PART_BYTES(PART_BYTES)) u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  // range derivation
  logic [brgt_pkg::PBYTES_W-1:0] psize;
  logic [DW:0]   pend;
  logic [DW-1:0] lim;
  logic [DW-1:0] rng_s, rng_e;
  logic          is_init, is_upd, is_query;

  assign is_init  = req_r == brgt_pkg::REQ_INIT_CLEAR || req_r == brgt_pkg::REQ_INIT_ALL;
  assign is_upd   = req_r == brgt_pkg::REQ_ADD || req_r == brgt_pkg::REQ_FILL;
  assign is_query = req_r == brgt_pkg::REQ_TOTAL || req_r == brgt_pkg::REQ_PART_SIZE
                    || req_r == brgt_pkg::REQ_COMPLETE;
  assign psize = ({1'b0, part_r} == last_part_number) ? last_part_bytes : PB;
  assign pend  = {1'b0, prod} + {{(DW + 1 - brgt_pkg::PBYTES_W){1'b0}}, psize} - 1'b1;
  assign lim   = file_size - 1'b1;

  always_comb begin
    rng_s = by_part_r ? prod : in_s;
    rng_e = by_part_r ? (pend[DW] ? brgt_pkg::MASK40 : pend[DW-1:0]) : in_e;
    if (req_r == brgt_pkg::REQ_TOTAL) begin
      rng_s = '0;
      rng_e = brgt_pkg::MASK40;
    end else if (req_r == brgt_pkg::REQ_PART_SIZE || req_r == brgt_pkg::REQ_COMPLETE) begin
      if (rng_e > lim) begin
        rng_e = lim;
      end
    end
  end

  // per-entry decision
  logic [DW:0]   e_p1, ge_p1;
  logic          add_before, add_after;
  logic          fill_left, fill_right, fill_out;
  logic [DW-1:0] ov_a, ov_b;
  logic [DW:0]   ov_len;
  logic [DW+1:0] ov_sum;
  logic [DW-1:0] acc_next;
  logic [1:0]    n_pc;
  logic [DW-1:0] p0s, p0e, p1s, p1e;
  logic          full;
  logic          more;

  assign e_p1       = {1'b0, e_r} + 1'b1;
  assign ge_p1      = {1'b0, g_e} + 1'b1;
  assign add_before = ge_p1 < {1'b0, s_r};
  assign add_after  = {1'b0, g_s} > e_p1;
  assign fill_out   = g_e < s_r || g_s > e_r;
  assign fill_left  = g_s < s_r;
  assign fill_right = g_e > e_r;
  assign ov_a       = (g_s > s_r) ? g_s : s_r;
  assign ov_b       = (g_e < e_r) ? g_e : e_r;
  assign ov_len     = {1'b0, ov_b - ov_a} + 1'b1;
  assign ov_sum     = {2'b0, acc} + {1'b0, ov_len};
  assign acc_next   = (ov_a > ov_b) ? acc
                    : ((ov_sum > {2'b0, brgt_pkg::MASK40}) ? brgt_pkg::MASK40 : ov_sum[DW-1:0]);
  assign full       = wr_n == FULL;
  assign more       = rd_idx < gap_count;

  always_comb begin
    n_pc = 2'd0;
    p0s  = g_s;
    p0e  = g_e;
    p1s  = g_s;
    p1e  = g_e;
    case (req_r)
      brgt_pkg::REQ_ADD: begin
        if (add_before) begin
          n_pc = 2'd1;
        end else if (add_after) begin
          if (!placed) begin
            n_pc = 2'd2;
            p0s  = ms;
            p0e  = me;
          end else begin
            n_pc = 2'd1;
          end
        end
      end
      brgt_pkg::REQ_FILL: begin
        if (fill_out) begin
          n_pc = 2'd1;
        end else if (fill_left && fill_right) begin
          n_pc = 2'd2;
          p0e  = s_r - 1'b1;
          p1s  = e_r + 1'b1;
        end else if (fill_left) begin
          n_pc = 2'd1;
          p0e  = s_r - 1'b1;
        end else if (fill_right) begin
          n_pc = 2'd1;
          p0s  = e_r + 1'b1;
        end
      end
      default: begin
        n_pc = 2'd0;
      end
    endcase
  end

  // memory port control
  logic scan_adv;
  logic init_wr;

  assign scan_adv = (state == ST_SCAN && proc_valid && n_pc != 2'd2 && !(n_pc != 2'd0 && full))
                 || (state == ST_SPLIT && !full);
  assign init_wr  = state == ST_DIV && div_rsp.done && req_r == brgt_pkg::REQ_INIT_ALL
                 && file_size != '0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_n[AW-1:0];
    mem_ws    = p0s;
    mem_wei   = p0e;
    case (state)
      ST_SCAN: begin
        if (proc_valid) begin
          mem_we = n_pc != 2'd0 && !full;
        end else begin
          mem_we  = req_r == brgt_pkg::REQ_ADD && !placed && !full;
          mem_ws  = ms;
          mem_wei = me;
        end
      end
      ST_SPLIT: begin
        mem_we  = !full;
        mem_ws  = hold_s;
        mem_wei = hold_e;
      end
      ST_DIV: begin
        mem_we    = init_wr;
        mem_waddr = '0;
        mem_ws    = '0;
        mem_wei   = lim;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re    = (state == ST_START) || (scan_adv && more);
  assign mem_raddr = (state == ST_START) ? '0 : rd_idx[AW-1:0];

  assign in_stall = state != ST_IDLE;
  assign div_req  = '{start: (state == ST_RANGE) && is_init, dividend: file_size};

  // sequencer
  logic out_load;
  assign out_load = state == ST_DONE && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      cur_bank         <= 1'b0;
      gap_count        <= '0;
      last_part_number <= '0;
      last_part_bytes  <= PB;
      proc_valid       <= 1'b0;
      placed           <= 1'b0;
      ovf              <= 1'b0;
      rd_idx           <= '0;
      wr_n             <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= ST_RANGE;
        end
        ST_RANGE: begin
          ovf    <= 1'b0;
          placed <= 1'b0;
          wr_n   <= '0;
          rd_idx <= '0;
          if (is_init) begin
            state <= ST_DIV;
          end else if (is_query || (is_upd && rng_s <= rng_e)) begin
            state <= ST_START;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            if (file_size == '0) begin
              last_part_number <= '0;
              last_part_bytes  <= PB;
            end else if (div_rsp.remainder == '0) begin
              last_part_number <= brgt_pkg::LPN_W'(div_rsp.quotient - 1'b1);
              last_part_bytes  <= PB;
            end else begin
              last_part_number <= brgt_pkg::LPN_W'(div_rsp.quotient);
              last_part_bytes  <= div_rsp.remainder;
            end
            if (init_wr) begin
              cur_bank  <= !cur_bank;
              gap_count <= CW'(1);
            end else begin
              gap_count <= '0;
            end
            state <= ST_DONE;
          end
        end
        ST_START: begin
          proc_valid <= gap_count != '0;
          rd_idx     <= CW'(1);
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (proc_valid) begin
            if (n_pc != 2'd0 && full) begin
              ovf   <= 1'b1;
              state <= ST_DONE;
            end else begin
              if (n_pc != 2'd0) begin
                wr_n <= wr_n + 1'b1;
              end
              if (n_pc == 2'd2 && req_r == brgt_pkg::REQ_ADD) begin
                placed <= 1'b1;
              end
              if (n_pc == 2'd2) begin
                state <= ST_SPLIT;
              end else begin
                proc_valid <= more;
                if (more) begin
                  rd_idx <= rd_idx + 1'b1;
                end
              end
            end
          end else begin
            state <= ST_DONE;
            if (req_r == brgt_pkg::REQ_ADD && !placed) begin
              if (full) begin
                ovf <= 1'b1;
              end else begin
                cur_bank  <= !cur_bank;
                gap_count <= wr_n + 1'b1;
              end
            end else if (is_upd) begin
              cur_bank  <= !cur_bank;
              gap_count <= wr_n;
            end
          end
        end
        ST_SPLIT: begin
          if (full) begin
            ovf   <= 1'b1;
            state <= ST_DONE;
          end else begin
            wr_n       <= wr_n + 1'b1;
            proc_valid <= more;
            if (more) begin
              rd_idx <= rd_idx + 1'b1;
            end
            state <= ST_SCAN;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_WAIT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_r     <= req_type;
      in_s      <= range_start;
      in_e      <= range_end;
      by_part_r <= by_part;
      part_r    <= part_index;
    end
    if (state == ST_PREP) begin
      prod <= {{(DW - brgt_pkg::PART_W){1'b0}}, part_r} * {{(DW - brgt_pkg::PBYTES_W){1'b0}}, PB};
    end
    if (state == ST_RANGE) begin
      s_r <= rng_s;
      e_r <= rng_e;
      ms  <= rng_s;
      me  <= rng_e;
      acc <= '0;
    end
    if (state == ST_SCAN && proc_valid) begin
      if (req_r == brgt_pkg::REQ_ADD && !add_before && !add_after) begin
        ms <= (g_s < ms) ? g_s : ms;
        me <= (g_e > me) ? g_e : me;
      end
      if (n_pc == 2'd2) begin
        hold_s <= p1s;
        hold_e <= p1e;
      end
      acc <= acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      gap_bytes   <= (req_r == brgt_pkg::REQ_TOTAL || req_r == brgt_pkg::REQ_PART_SIZE)
                     ? acc : '0;
      is_complete <= req_r == brgt_pkg::REQ_COMPLETE && acc == '0;
      overflow    <= ovf;
    end
  end

  `BRGT_ASSERT(a_busy_after_transfer, clk, rst, (in_valid && !in_stall) |=> (state != ST_IDLE), "request transfer did not start work")
  `BRGT_ASSERT_NEVER(a_count_in_range, clk, rst, gap_count > FULL, "gap count above table depth")
  `BRGT_ASSERT(a_ovf_alone, clk, rst, (out_valid && overflow) |-> (gap_bytes == '0 && !is_complete), "overflow result carries query data")

endmodule

/* sim/brgt_checker.sv */
// Checker for the byte range gap tracker: predicts each result and compares it.
`timescale 1ns / 1ps
module brgt_checker #(
  parameter int MAX_GAPS = brgt_pkg::MAX_GAPS_DEFAULT,
  parameter int PART_BYTES = brgt_pkg::PART_BYTES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [2:0]                  req_type,
  input  logic [brgt_pkg::DATA_W-1:0] range_start,
  input  logic [brgt_pkg::DATA_W-1:0] range_end,
  input  logic                        by_part,
  input  logic [brgt_pkg::PART_W-1:0] part_index,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [brgt_pkg::DATA_W-1:0] gap_bytes,
  input  logic                        is_complete,
  input  logic                        overflow,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending,
  output int                          overflow_seen,
  output int                          split_seen
);

  typedef struct packed {
    logic [brgt_pkg::DATA_W-1:0] bytes;
    logic                        done;
    logic                        ovf;
  } answer_t;

  answer_t answers_due[$];

  logic [63:0] size_reg;
  logic [63:0] gs[MAX_GAPS];
  logic [63:0] ge[MAX_GAPS];
  int          ng;
  logic [63:0] lpn;
  logic [63:0] lpb;
  logic [63:0] ts[MAX_GAPS];
  logic [63:0] te[MAX_GAPS];
  int          tn;

  assign pending = answers_due.size();

  function automatic bit stash(logic [63:0] s, logic [63:0] e);
    if (tn >= MAX_GAPS) return 0;
    ts[tn] = s;
    te[tn] = e;
    tn++;
    return 1;
  endfunction

  function automatic void take_table();
    for (int i = 0; i < tn; i++) begin
      gs[i] = ts[i];
      ge[i] = te[i];
    end
    ng = tn;
  endfunction

  function automatic bit merge_gap(logic [63:0] s, logic [63:0] e);
    logic [63:0] ms, me;
    bit placed;
    ms = s;
    me = e;
    placed = 0;
    tn = 0;
    if (s > e) return 1;
    for (int i = 0; i < ng; i++)
      if (gs[i] <= e + 1 && ge[i] + 1 >= s) begin
        if (gs[i] < ms) ms = gs[i];
        if (ge[i] > me) me = ge[i];
      end
    for (int i = 0; i < ng; i++) begin
      if (ge[i] + 1 < s) begin
        if (!stash(gs[i], ge[i])) return 0;
      end else if (gs[i] > e + 1) begin
        if (!placed) begin
          if (!stash(ms, me)) return 0;
          placed = 1;
        end
        if (!stash(gs[i], ge[i])) return 0;
      end
    end
    if (!placed && !stash(ms, me)) return 0;
    take_table();
    return 1;
  endfunction

  function automatic bit carve_gap(logic [63:0] s, logic [63:0] e);
    tn = 0;
    if (s > e) return 1;
    for (int i = 0; i < ng; i++) begin
      if (ge[i] < s || gs[i] > e) begin
        if (!stash(gs[i], ge[i])) return 0;
      end else begin
        if (gs[i] < s && ge[i] > e) split_seen++;
        if (gs[i] < s && !stash(gs[i], s - 1)) return 0;
        if (ge[i] > e && !stash(e + 1, ge[i])) return 0;
      end
    end
    take_table();
    return 1;
  endfunction

  function automatic logic [63:0] missing_bytes(logic [63:0] s, logic [63:0] e);
    logic [63:0] sum, a, b;
    sum = 0;
    if (s > e) return 0;
    for (int i = 0; i < ng; i++) begin
      a = gs[i] > s ? gs[i] : s;
      b = ge[i] < e ? ge[i] : e;
      if (a <= b) sum += b - a + 1;
    end
    return sum > 64'(brgt_pkg::MASK40) ? 64'(brgt_pkg::MASK40) : sum;
  endfunction

  function automatic answer_t predict_answer(logic [2:0] rq, logic [63:0] s_in,
                                             logic [63:0] e_in, logic bp,
                                             logic [63:0] pi);
    answer_t a;
    logic [63:0] s, e, sz, lim, q, r;
    a = '0;
    s = s_in;
    e = e_in;
    lim = (size_reg - 1) & 64'(brgt_pkg::MASK40);
    if (bp) begin
      sz = (pi == lpn) ? lpb : 64'(PART_BYTES);
      s = pi * PART_BYTES;
      e = (sz == 0) ? s : s + sz - 1;
      if (s > 64'(brgt_pkg::MASK40)) s = 64'(brgt_pkg::MASK40);
      if (e > 64'(brgt_pkg::MASK40)) e = 64'(brgt_pkg::MASK40);
    end
    case (rq)
      brgt_pkg::REQ_INIT_CLEAR, brgt_pkg::REQ_INIT_ALL: begin
        if (size_reg == 0) begin
          lpn = 0;
          lpb = PART_BYTES;
        end else begin
          q = size_reg / PART_BYTES;
          r = size_reg % PART_BYTES;
          if (r == 0) begin
            r = PART_BYTES;
            q = q - 1;
          end
          lpn = q & 64'h1FFFF;
          lpb = r;
        end
        ng = 0;
        if (rq == brgt_pkg::REQ_INIT_ALL && size_reg != 0) begin
          gs[0] = 0;
          ge[0] = size_reg - 1;
          ng = 1;
        end
      end
      brgt_pkg::REQ_ADD: a.ovf = !merge_gap(s, e);
      brgt_pkg::REQ_FILL: a.ovf = !carve_gap(s, e);
      brgt_pkg::REQ_TOTAL: a.bytes = missing_bytes(0, 64'(brgt_pkg::MASK40));
      brgt_pkg::REQ_PART_SIZE: begin
        if (e > lim) e = lim;
        a.bytes = missing_bytes(s, e);
      end
      brgt_pkg::REQ_COMPLETE: begin
        if (e > lim) e = lim;
        a.done = (s > e || missing_bytes(s, e) == 0);
      end
      default: ;
    endcase
    if (a.ovf) overflow_seen++;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      size_reg <= 1;
      ng = 0;
      lpn = 0;
      lpb = PART_BYTES;
      fail_count <= 0;
      overflow_seen = 0;
      split_seen = 0;
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 4'd0)
        size_reg <= pwdata & 64'(brgt_pkg::MASK40);
      if (in_valid && !in_stall)
        answers_due.push_back(predict_answer(req_type, 64'(range_start),
                                             64'(range_end), by_part, 64'(part_index)));
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with none expected: got bytes %0d complete %0b ovf %0b",
                   $time, gap_bytes, is_complete, overflow);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          if (want.bytes !== gap_bytes || want.done !== is_complete ||
              want.ovf !== overflow) begin
            $display("%0t: mismatch: expected bytes %0d complete %0b ovf %0b, got %0d %0b %0b",
                     $time, want.bytes, want.done, want.ovf, gap_bytes, is_complete,
                     overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_byte_range_gap_tracker.sv */
// Testbench top for the byte range gap tracker: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_byte_range_gap_tracker;

  localparam int MAX_GAPS = brgt_pkg::MAX_GAPS_DEFAULT;
  localparam int PART_BYTES = brgt_pkg::PART_BYTES_DEFAULT;
  localparam longint LIMIT = 4000000;

  logic                        clk = 0;
  logic                        rst = 1;
  logic                        in_valid = 0;
  logic                        in_stall;
  logic [2:0]                  req_type = '0;
  logic [brgt_pkg::DATA_W-1:0] range_start = '0;
  logic [brgt_pkg::DATA_W-1:0] range_end = '0;
  logic                        by_part = 0;
  logic [brgt_pkg::PART_W-1:0] part_index = '0;
  logic                        out_valid;
  logic                        out_stall = 0;
  logic [brgt_pkg::DATA_W-1:0] gap_bytes;
  logic                        is_complete;
  logic                        overflow;
  logic                        psel = 0;
  logic                        penable = 0;
  logic                        pwrite = 0;
  logic [3:0]                  paddr = '0;
  logic [63:0]                 pwdata = '0;
  logic [63:0]                 prdata;
  logic                        pready;

  int     fail_count, pending, overflow_seen, split_seen;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     sent = 0;
  longint cycles = 0;
  logic [63:0] cur_size = 1;

  always #10 clk = ~clk;

  byte_range_gap_tracker #(.MAX_GAPS(MAX_GAPS), .PART_BYTES(PART_BYTES)) i_dut (.*);

  brgt_checker #(.MAX_GAPS(MAX_GAPS), .PART_BYTES(PART_BYTES)) i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_size(logic [63:0] v);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= 4'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    cur_size = v & 64'(brgt_pkg::MASK40);
  endtask

  // Drop valid, hold until every result is back, then let any trailing work settle.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Valid stays high after the transfer so the next request can follow at once.
  task automatic send(brgt_pkg::req_t rq, logic [63:0] s, logic [63:0] e, logic bp,
                      logic [15:0] pi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rq;
    range_start <= s[brgt_pkg::DATA_W-1:0];
    range_end <= e[brgt_pkg::DATA_W-1:0];
    by_part <= bp;
    part_index <= pi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Mostly small ranges inside the file so gaps pile up and split.
  task automatic random_item();
    logic [63:0] s, e, span;
    logic [15:0] pi;
    int pick;
    brgt_pkg::req_t rq;
    pick = $urandom_range(99);
    if (pick < 2) rq = brgt_pkg::REQ_INIT_ALL;
    else if (pick < 3) rq = brgt_pkg::REQ_INIT_CLEAR;
    else if (pick < 40) rq = brgt_pkg::REQ_ADD;
    else if (pick < 65) rq = brgt_pkg::REQ_FILL;
    else if (pick < 72) rq = brgt_pkg::REQ_TOTAL;
    else if (pick < 86) rq = brgt_pkg::REQ_PART_SIZE;
    else rq = brgt_pkg::REQ_COMPLETE;
    span = (cur_size > 1) ? cur_size : 64'd1000;
    s = {$urandom, $urandom} % span;
    e = s + ($urandom_range(3) == 0 ? {$urandom, $urandom} % span : $urandom_range(40));
    if ($urandom_range(19) == 0) s = {$urandom, $urandom};
    if ($urandom_range(19) == 0) e = {$urandom, $urandom};
    pi = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    send(rq, s, e, $urandom_range(5) == 0, pi);
  endtask

  initial begin
    logic [63:0] sizes[6];
    sizes = '{64'd1, 64'(PART_BYTES), 64'd3 * PART_BYTES + 5, 64'(brgt_pkg::MASK40), 64'd0,
              64'd50000};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: init forms, adjacency merge, split, overflow, clamping, part ranges.
    write_size(64'd3 * PART_BYTES + 5);
    send(brgt_pkg::REQ_INIT_ALL, 0, 0, 0, 0);
    send(brgt_pkg::REQ_TOTAL, 0, 0, 0, 0);
    send(brgt_pkg::REQ_FILL, 100, 199, 0, 0);
    send(brgt_pkg::REQ_PART_SIZE, 0, 0, 1, 0);
    send(brgt_pkg::REQ_PART_SIZE, 0, 0, 1, 3);
    send(brgt_pkg::REQ_COMPLETE, 100, 199, 0, 0);
    send(brgt_pkg::REQ_COMPLETE, 0, 64'(brgt_pkg::MASK40), 0, 0);
    send(brgt_pkg::REQ_INIT_CLEAR, 0, 0, 0, 0);
    send(brgt_pkg::REQ_ADD, 10, 19, 0, 0);
    send(brgt_pkg::REQ_ADD, 20, 29, 0, 0);
    send(brgt_pkg::REQ_ADD, 40, 30, 0, 0);
    send(brgt_pkg::REQ_FILL, 40, 30, 0, 0);
    send(brgt_pkg::REQ_PART_SIZE, 40, 30, 0, 0);
    send(brgt_pkg::REQ_COMPLETE, 40, 30, 0, 0);
    send(brgt_pkg::REQ_ADD, 0, 0, 1, 16'hFFFF);
    send(brgt_pkg::REQ_TOTAL, 0, 0, 0, 0);
    send(brgt_pkg::REQ_FILL, 0, 64'(brgt_pkg::MASK40), 0, 0);
    send(brgt_pkg::req_t'(3'd7), 64'(brgt_pkg::MASK40), 64'(brgt_pkg::MASK40), 1, 16'hFFFF);
    for (int i = 0; i < MAX_GAPS + 1; i++)
      send(brgt_pkg::REQ_ADD, 64'(i) * 4, 64'(i) * 4 + 1, 0, 0);
    send(brgt_pkg::REQ_FILL, 1, 1, 0, 0);
    send(brgt_pkg::REQ_TOTAL, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_size(sizes[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      send(brgt_pkg::REQ_INIT_ALL, 0, 0, 0, 0);
      for (int k = 0; k < 280; k++) random_item();
      drain();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (300) @(posedge clk);
    $display("sent %0d requests over six file sizes and four idling mixes", sent);
    $display("overflows predicted %0d, gap splits predicted %0d", overflow_seen, split_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
